// ===== hdl/mks_pkg.sv =====
// Package for the 4x4 keypad scanner: widths, reset values and the key code table.
package mks_pkg;

   localparam int unsigned ROWS        = 4;
   localparam int unsigned COLS        = 4;
   localparam int unsigned ROW_W       = 2;
   localparam int unsigned SETTLE_W    = 16;
   localparam int unsigned KEY_W       = 7;
   localparam int unsigned REQ_DATA_W  = 8;
   localparam int unsigned RSP_DATA_W  = 16;

   localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd5000;

   typedef logic [KEY_W-1:0] key_type;

   // One result word as it leaves the scanner.
   typedef struct packed {
      logic          scan_done;
      key_type       key_code;
      logic [ROWS-1:0] row_drive;
   } rsp_word_type;

   // Key codes, row by row, column 0 in the lowest slot.
   localparam key_type KEY_TABLE [ROWS][COLS] = '{
      '{7'd7,  7'd8, 7'd9,   7'd119},
      '{7'd4,  7'd5, 7'd6,   7'd124},
      '{7'd1,  7'd2, 7'd3,   7'd57},
      '{7'd94, 7'd0, 7'd121, 7'd113}
   };

   function automatic key_type key_lookup(input logic [ROW_W-1:0] row,
                                          input logic [ROW_W-1:0] col);
      return KEY_TABLE[row][col];
   endfunction

endpackage

// ===== hdl/matrix_keypad_scanner.sv =====
// Top level of the 4x4 keypad scanner: row sequencing, column sampling, output skid.
//
//   channel | direction | payload                                   | handshake
//   --------+-----------+-------------------------------------------+------------------
//   req     | in        | tdata[3:0] column_levels                  | tvalid / tready
//   rsp     | out       | tdata[3:0] row_drive, [10:4] key_code;    | tvalid / tready
//           |           | tlast scan_done                           |
//   csr     | in        | wdata settle_ticks                        | we, no wait
//
// One word per clock while req_tready is high: the scan state updates in the cycle a req
// word is accepted and its result is registered at the same edge.
// A two-entry output (result register plus skid register) keeps req_tready high while
// one result waits; req_tready drops only when both entries hold results.
// Synchronous active-high reset: row 0 driven, settle count and key code zero,
// settle_ticks 5000. Write the CSR only while no word is in flight.
module matrix_keypad_scanner (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_we,
   input  logic [mks_pkg::SETTLE_W-1:0]    csr_wdata,   // settle_ticks
   // tick stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mks_pkg::REQ_DATA_W-1:0]  req_tdata,   // [3:0] column_levels, rest zero
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mks_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [3:0] row_drive, [10:4] key_code
   output logic                            rsp_tlast    // scan_done
);

   // scan state
   logic [mks_pkg::SETTLE_W-1:0]  settle_ticks_ff;
   logic [mks_pkg::ROW_W-1:0]     row_index_ff, row_index_in;
   logic [mks_pkg::SETTLE_W-1:0]  settle_count_ff, settle_count_in;
   mks_pkg::key_type              held_key_ff, held_key_in;

   // output register and skid entry
   mks_pkg::rsp_word_type         out_word_ff, out_word_in;
   logic                          out_valid_ff, out_valid_in;
   mks_pkg::rsp_word_type         skid_word_ff, skid_word_in;
   logic                          skid_valid_ff, skid_valid_in;

   logic                          accept;
   logic                          sample;
   logic [mks_pkg::SETTLE_W:0]    ticks;
   logic [mks_pkg::COLS-1:0]      cols;
   mks_pkg::rsp_word_type         new_word;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign cols       = req_tdata[mks_pkg::COLS-1:0];

   // Sample on the tick that brings the count up to the settle time; zero acts as one.
   assign ticks  = {1'b0, settle_count_ff} + {{mks_pkg::SETTLE_W{1'b0}}, 1'b1};
   assign sample = (settle_ticks_ff == '0) || (ticks >= {1'b0, settle_ticks_ff});

   always_comb begin
      held_key_in     = held_key_ff;
      row_index_in    = row_index_ff;
      settle_count_in = settle_count_ff;
      if (sample) begin
         // highest active column of this row wins
         for (int j = 0; j < mks_pkg::COLS; j++) begin
            if (cols[j]) begin
               held_key_in = mks_pkg::key_lookup(row_index_ff, mks_pkg::ROW_W'(j));
            end
         end
         row_index_in    = row_index_ff + mks_pkg::ROW_W'(1);
         settle_count_in = '0;
      end else begin
         settle_count_in = ticks[mks_pkg::SETTLE_W-1:0];
      end
   end

   always_comb begin
      new_word.row_drive = mks_pkg::ROWS'(1) << row_index_ff;
      new_word.key_code  = held_key_in;
      new_word.scan_done = sample && (row_index_ff == mks_pkg::ROW_W'(mks_pkg::ROWS - 1));
   end

   // Output pair: refill the result register from the skid first, else from a new word.
   always_comb begin
      out_word_in   = out_word_ff;
      out_valid_in  = out_valid_ff;
      skid_word_in  = skid_word_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_word_in   = skid_word_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_word_in  = new_word;
            out_valid_in = accept;
         end
      end else if (accept) begin
         // hold the stalled result, park the new one
         skid_word_in  = new_word;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff <= mks_pkg::SETTLE_RESET;
         row_index_ff    <= '0;
         settle_count_ff <= '0;
         held_key_ff     <= '0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            settle_ticks_ff <= csr_wdata;
         end
         if (accept) begin
            row_index_ff    <= row_index_in;
            settle_count_ff <= settle_count_in;
            held_key_ff     <= held_key_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(mks_pkg::RSP_DATA_W - mks_pkg::ROWS - mks_pkg::KEY_W){1'b0}},
                        out_word_ff.key_code, out_word_ff.row_drive};
   assign rsp_tlast  = out_word_ff.scan_done;

   // skid entry is only ever filled behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty result register");

   // every shown word drives exactly one row
   a_row_onehot: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot(out_word_ff.row_drive))
      else $error("row drive not one-hot");

   // end of pass is flagged only on the last row
   a_done_last_row: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.scan_done) |-> out_word_ff.row_drive[mks_pkg::ROWS-1])
      else $error("scan_done on a row other than the last");

   // the scan only moves on accepted ticks
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(row_index_ff) && $stable(settle_count_ff) && $stable(held_key_ff)))
      else $error("scan state moved without an accepted tick");

   // the key code changes only on a sampling tick
   a_key_on_sample: assert property (@(posedge clock) disable iff (reset)
      (accept && !sample) |=> $stable(held_key_ff))
      else $error("key code changed between samples");

endmodule

// ===== tb/tb_matrix_keypad_scanner.sv =====
// Self-checking testbench for the 4x4 keypad scanner: predicted key codes against the rsp stream.
`timescale 1ns / 100ps

module tb_matrix_keypad_scanner;

   localparam int unsigned CLOCK_HALF  = 4;
   localparam int unsigned RESET_CYCLES = 11;
   localparam int unsigned LONG_HOLD   = 80;    // receiver hold-off that fills both output entries
   localparam int unsigned QUIET_LIMIT = 2000;  // cycles without any handshake before giving up
   localparam int unsigned DRAIN_TAIL  = 8;     // idle tail after the final drain, leaves some slack

   // Tracks the scan position and held key, and keeps the result words still to come.
   class keypad_scoreboard;
      logic [mks_pkg::SETTLE_W-1:0] settle;
      logic [mks_pkg::ROW_W-1:0]    row;
      logic [mks_pkg::SETTLE_W-1:0] ticks_in_row;
      mks_pkg::key_type             held;
      mks_pkg::rsp_word_type        pending_q[$];
      int                           mismatches;

      function new();
         settle       = mks_pkg::SETTLE_RESET;
         row          = '0;
         ticks_in_row = '0;
         held         = '0;
         mismatches   = 0;
      endfunction

      function void set_settle(input logic [mks_pkg::SETTLE_W-1:0] value);
         settle = value;
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction

      // Advance the scan by one tick and queue the word it produces.
      function void note_word(input logic [mks_pkg::COLS-1:0] cols);
         mks_pkg::rsp_word_type        w;
         logic [mks_pkg::SETTLE_W:0]   limit;
         logic [mks_pkg::SETTLE_W:0]   ticks;
         limit = (settle == '0) ? {{mks_pkg::SETTLE_W{1'b0}}, 1'b1} : {1'b0, settle};
         ticks = {1'b0, ticks_in_row} + {{mks_pkg::SETTLE_W{1'b0}}, 1'b1};
         w.row_drive = 4'b0001 << row;
         w.scan_done = 1'b0;
         if (ticks >= limit) begin
            // later columns overwrite earlier ones: highest active column wins
            for (int j = 0; j < mks_pkg::COLS; j++) begin
               if (cols[j])
                  held = mks_pkg::KEY_TABLE[row][j];
            end
            w.scan_done  = (row == mks_pkg::ROWS - 1);
            row          = row + 1'b1;
            ticks_in_row = '0;
         end else begin
            ticks_in_row = ticks[mks_pkg::SETTLE_W-1:0];
         end
         w.key_code = held;
         pending_q.push_back(w);
      endfunction

      function void report(input string what);
         if (mismatches < 10)
            $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endfunction

      function void check_result(input logic [mks_pkg::RSP_DATA_W-1:0] data, input logic last);
         mks_pkg::rsp_word_type w;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected word tdata=%h tlast=%b", data, last));
            return;
         end
         w = pending_q.pop_front();
         if (data[3:0] !== w.row_drive)
            report($sformatf("row_drive exp %b got %b", w.row_drive, data[3:0]));
         if (data[10:4] !== w.key_code)
            report($sformatf("key_code exp %0d got %0d", w.key_code, data[10:4]));
         if (last !== w.scan_done)
            report($sformatf("scan_done exp %b got %b", w.scan_done, last));
         if (data[mks_pkg::RSP_DATA_W-1:11] !== '0)
            report($sformatf("tdata pad exp 0 got %h", data[mks_pkg::RSP_DATA_W-1:11]));
      endfunction
   endclass

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             csr_we     = 1'b0;
   logic [mks_pkg::SETTLE_W-1:0]     csr_wdata  = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [mks_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [mks_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             rsp_tlast;

   keypad_scoreboard sb = new();

   int          tx_idle_pct  = 0;   // chance per cycle that the sender holds back
   int          rx_idle_pct  = 0;   // chance per cycle that the receiver stalls
   logic        hold_pending = 1'b0;
   int unsigned hold_left    = 0;
   int unsigned quiet_cycles = 0;

   matrix_keypad_scanner u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Receiver: check every accepted word, then pick next cycle's tready.
   // A requested long hold-off drops tready for a LONG_HOLD stretch while the
   // sender keeps pushing, so both output entries fill and req_tready falls.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tlast);
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_pending) begin
         hold_pending <= 1'b0;
         hold_left    <= LONG_HOLD;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Watchdog: any handshake on either stream counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("tb_matrix_keypad_scanner: FAIL");
         $finish;
      end
   end

   // Offer one tick word, with random idle cycles ahead of it; hold until taken.
   // tvalid stays high on return, so the caller must drive the next word or drop
   // it in the same time step.
   task automatic send_tick(input logic [mks_pkg::COLS-1:0] cols);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(mks_pkg::REQ_DATA_W-mks_pkg::COLS){1'b0}}, cols};
      do @(posedge clock); while (!req_tready);
      sb.note_word(cols);
   endtask

   // Drop tvalid and wait for every result before touching the register.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_settle(input logic [mks_pkg::SETTLE_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_settle(value);
   endtask

   // Key pattern that persists for a while, like a finger on the pad,
   // with occasional one-tick glitches.
   task automatic send_random_ticks(input int n);
      logic [mks_pkg::COLS-1:0] pattern;
      logic [mks_pkg::COLS-1:0] cols;
      pattern = '0;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0)
            pattern = ($urandom_range(99) < 40) ? 4'h0 : 4'($urandom_range(1, 15));
         cols = pattern;
         if ($urandom_range(19) == 0)
            cols = 4'($urandom_range(0, 15));
         send_tick(cols);
      end
   endtask

   initial begin
      logic [mks_pkg::SETTLE_W-1:0] settle_pick;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settle time: row 0 is held, no sample falls in this stretch.
      send_random_ticks(300);

      // Settle of one: every tick samples. Walk every key of every row,
      // then all columns at once (highest wins) and nothing pressed (code kept).
      write_settle(16'd1);
      for (int j = 0; j < mks_pkg::COLS; j++)
         for (int r = 0; r < mks_pkg::ROWS; r++)
            send_tick(4'b0001 << j);
      send_tick(4'hF);
      send_tick(4'h0);
      send_tick(4'h9);
      send_tick(4'h6);

      // Zero settle behaves as one.
      write_settle(16'd0);
      send_tick(4'hF);
      send_tick(4'h0);
      send_tick(4'h3);
      send_tick(4'hC);

      // Lower the settle time mid-row: row is sampled on the next tick.
      write_settle(16'd10);
      repeat (7) send_tick(4'h5);
      write_settle(16'd3);
      send_tick(4'hA);
      send_tick(4'h1);
      send_tick(4'h0);

      // Random part: receiver-heavy idling, sender-heavy idling, then none.
      for (int mode = 0; mode < 3; mode++) begin
         tx_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 53 : 0;
         rx_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 35 : 0;
         for (int sub = 0; sub < 5; sub++) begin
            settle_pick = ($urandom_range(3) == 0) ? 16'($urandom_range(9, 40))
                                                   : 16'($urandom_range(1, 6));
            write_settle(settle_pick);
            if (mode == 2 && sub == 0)
               hold_pending <= 1'b1;
            send_random_ticks(100);
         end
      end

      // Largest settle time: the row is held, no sample within the stretch.
      write_settle(16'hFFFF);
      send_random_ticks(100);

      drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("tb_matrix_keypad_scanner: PASS");
      end else begin
         $display("tb_matrix_keypad_scanner: FAIL");
      end
      $finish;
   end

endmodule

// ===== matrix_keypad_scanner.f =====
hdl/mks_pkg.sv
hdl/matrix_keypad_scanner.sv
tb/tb_matrix_keypad_scanner.sv
